[hw/rtl/rrp_pkg.sv]
// Shared types and constants for the remote relay panel logic.
// Holds the request/response beat structs, register indexes and mode codes.
// No dependencies.
`default_nettype none

package rrp_pkg;

   localparam logic [7:0]  PRESSED_CODE = 8'h31;
   localparam logic [15:0] HOLD_RESET   = 16'd50;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned HOLD_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOGGLE_A_HOLD   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOGGLE_B_HOLD   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ON_HOLD    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_TURBO_HOLD = 8'd3;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_TURBO = 2'd2;

   typedef struct packed {
      logic [7:0] pair1_up_byte;
      logic [7:0] pair1_down_byte;
      logic [7:0] pair2_up_byte;
      logic [7:0] pair2_down_byte;
      logic [7:0] toggle_a_byte;
      logic [7:0] toggle_b_byte;
      logic [7:0] enable_byte;
      logic [7:0] turbo_path_byte;
      logic [7:0] on_path_byte;
   } req_type;

   typedef struct packed {
      logic       relay1;
      logic       relay2;
      logic       relay3;
      logic       relay4;
      logic       relay5;
      logic       relay6;
      logic       run_lamp;
      logic       turbo_lamp;
      logic       activity_lamp;
      logic [1:0] mode_now;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/remote_relay_panel_logic.sv]
// Remote relay panel logic: interlocked pairs, exclusive toggles, mode machine.
// Depends on rrp_pkg for beat structs, register indexes and mode codes.
// Request beat to response beat passes the input register, then the result register.
// One beat per cycle while rsp_stall is low; state updates in the single compute stage.
// Reset: synchronous active high; relays off, locks clear, mode idle, holds 50,
// timers 50 except the turbo timer at 0. No clearing pass.
`default_nettype none

module remote_relay_panel_logic
   import rrp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_type                req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_type                rsp_data,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [HOLD_W-1:0]      csr_data
);

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff;

   logic [HOLD_W-1:0]  tog_a_hold_ff, tog_b_hold_ff, on_hold_ff, turbo_hold_ff;
   logic [3:0]         relay_ff, relay_in;
   logic [3:0]         lock_ff, lock_in;
   logic               tog_a_ff, tog_a_in, tog_b_ff, tog_b_in;
   logic [1:0]         mode_ff, mode_in;
   logic [HOLD_W-1:0]  tmr_a_ff, tmr_a_in, tmr_b_ff, tmr_b_in;
   logic [HOLD_W-1:0]  tmr_on_ff, tmr_on_in, tmr_turbo_ff, tmr_turbo_in;
   rsp_type            out_data_in;

   logic out_ready;
   logic advance;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   function automatic logic [HOLD_W-1:0] count_down(input logic [HOLD_W-1:0] t);
      count_down = (t != '0) ? t - HOLD_W'(1) : '0;
   endfunction

   always_comb begin
      logic p1u, p1d, p2u, p2d, ta, tb, en, tp, op;
      logic [HOLD_W-1:0] ta_t, tb_t, on_t, tu_t;
      p1u = (in_data_ff.pair1_up_byte   == PRESSED_CODE);
      p1d = (in_data_ff.pair1_down_byte == PRESSED_CODE);
      p2u = (in_data_ff.pair2_up_byte   == PRESSED_CODE);
      p2d = (in_data_ff.pair2_down_byte == PRESSED_CODE);
      ta  = (in_data_ff.toggle_a_byte   == PRESSED_CODE);
      tb  = (in_data_ff.toggle_b_byte   == PRESSED_CODE);
      en  = (in_data_ff.enable_byte     == PRESSED_CODE);
      tp  = (in_data_ff.turbo_path_byte == PRESSED_CODE);
      op  = (in_data_ff.on_path_byte    == PRESSED_CODE);

      relay_in = relay_ff;
      lock_in  = lock_ff;
      // pair one: relays 0 and 1
      if (!p1u) begin
         relay_in[0] = 1'b0;
         lock_in[1]  = 1'b0;
      end
      if (!p1d) begin
         relay_in[1] = 1'b0;
         lock_in[0]  = 1'b0;
      end
      if (p1u && !lock_in[0]) begin
         relay_in[0] = 1'b1;
         lock_in[1]  = 1'b1;
      end
      if (p1d && !lock_in[1]) begin
         relay_in[1] = 1'b1;
         lock_in[0]  = 1'b1;
      end
      // pair two: relays 2 and 3
      if (!p2u) begin
         relay_in[2] = 1'b0;
         lock_in[3]  = 1'b0;
      end
      if (!p2d) begin
         relay_in[3] = 1'b0;
         lock_in[2]  = 1'b0;
      end
      if (p2u && !lock_in[2]) begin
         relay_in[2] = 1'b1;
         lock_in[3]  = 1'b1;
      end
      if (p2d && !lock_in[3]) begin
         relay_in[3] = 1'b1;
         lock_in[2]  = 1'b1;
      end

      tog_a_in = tog_a_ff;
      tog_b_in = tog_b_ff;
      ta_t     = tmr_a_ff;
      tb_t     = tmr_b_ff;
      if (ta && tmr_a_ff == '0) begin
         if (!tog_a_in) begin
            if (!tog_b_in) begin
               tog_a_in = 1'b1;
            end
            tog_b_in = 1'b0;
         end else begin
            tog_a_in = 1'b0;
         end
         ta_t = tog_a_hold_ff;
      end
      if (tb && tmr_b_ff == '0) begin
         if (!tog_b_in) begin
            if (!tog_a_in) begin
               tog_b_in = 1'b1;
            end
            tog_a_in = 1'b0;
         end else begin
            tog_b_in = 1'b0;
         end
         tb_t = tog_b_hold_ff;
      end

      mode_in = mode_ff;
      on_t    = tmr_on_ff;
      tu_t    = tmr_turbo_ff;
      if (en && op && tmr_on_ff == '0) begin
         if (!tp) begin
            mode_in = (mode_in == MODE_ON) ? MODE_IDLE : MODE_ON;
         end
         on_t = on_hold_ff;
      end
      if (en && tp && tmr_turbo_ff == '0) begin
         if (!op) begin
            mode_in = (mode_in == MODE_TURBO) ? MODE_IDLE : MODE_TURBO;
         end
         tu_t = turbo_hold_ff;
      end

      tmr_a_in     = count_down(ta_t);
      tmr_b_in     = count_down(tb_t);
      tmr_on_in    = count_down(on_t);
      tmr_turbo_in = count_down(tu_t);

      out_data_in.relay1        = relay_in[0];
      out_data_in.relay2        = relay_in[1];
      out_data_in.relay3        = relay_in[2];
      out_data_in.relay4        = relay_in[3];
      out_data_in.relay5        = tog_a_in;
      out_data_in.relay6        = tog_b_in;
      out_data_in.run_lamp      = (mode_in != MODE_IDLE);
      out_data_in.turbo_lamp    = (mode_in == MODE_TURBO);
      out_data_in.activity_lamp = |in_data_ff;
      out_data_in.mode_now      = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         tog_a_hold_ff <= HOLD_RESET;
         tog_b_hold_ff <= HOLD_RESET;
         on_hold_ff    <= HOLD_RESET;
         turbo_hold_ff <= HOLD_RESET;
         relay_ff      <= '0;
         lock_ff       <= '0;
         tog_a_ff      <= 1'b0;
         tog_b_ff      <= 1'b0;
         mode_ff       <= MODE_IDLE;
         tmr_a_ff      <= HOLD_RESET;
         tmr_b_ff      <= HOLD_RESET;
         tmr_on_ff     <= HOLD_RESET;
         tmr_turbo_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TOGGLE_A_HOLD:   tog_a_hold_ff <= csr_data;
               CSR_TOGGLE_B_HOLD:   tog_b_hold_ff <= csr_data;
               CSR_MODE_ON_HOLD:    on_hold_ff    <= csr_data;
               CSR_MODE_TURBO_HOLD: turbo_hold_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            relay_ff     <= relay_in;
            lock_ff      <= lock_in;
            tog_a_ff     <= tog_a_in;
            tog_b_ff     <= tog_b_in;
            mode_ff      <= mode_in;
            tmr_a_ff     <= tmr_a_in;
            tmr_b_ff     <= tmr_b_in;
            tmr_on_ff    <= tmr_on_in;
            tmr_turbo_ff <= tmr_turbo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode_now <= MODE_TURBO))
      else $error("mode code out of range");

   a_pair_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.relay1 && rsp_data.relay2) &&
                    !(rsp_data.relay3 && rsp_data.relay4))
      else $error("interlocked pair relays both on");

   a_toggle_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.relay5 && rsp_data.relay6))
      else $error("toggle relays both on");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff && out_valid_ff)
      else $error("beat lost under stall");

endmodule

`default_nettype wire
